@@ rtl/double_ended_queue_assert.svh @@
// Assertion macros for the double-ended queue.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define DQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQ_ASSERT_IMPLY(label, ante, cons, msg)
`define DQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/dq_pkg.sv @@
// Shared constants, codes and types of the double-ended queue.
// No dependencies; every other file but the assertion header depends on this package.
package dq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned OP_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_BACK    = 3'd1,
    OP_POP_FRONT    = 3'd2,
    OP_POP_BACK     = 3'd3,
    OP_PEEK_FRONT   = 3'd4,
    OP_PEEK_BACK    = 3'd5,
    OP_READ_INDEX   = 3'd6,
    OP_REMOVE_INDEX = 3'd7
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } dq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRAB,
    S_SHIFT,
    S_RESP
  } dq_state_t;

  // One access to the entry store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } dq_mem_req_t;

  // One result item.
  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    dq_status_t         status;
    logic [COUNT_W-1:0] entry_count;
  } dq_rsp_t;

endpackage

@@ rtl/dq_if.sv @@
// Valid/ready channel interfaces for the request and result items.
// Depends on dq_pkg for the field widths.
interface dq_in_if;
  logic                      valid;
  logic                      ready;
  logic [dq_pkg::OP_W-1:0]   op;
  logic [dq_pkg::DATA_W-1:0] data_in;
  logic [dq_pkg::IDX_W-1:0]  item_index;

  modport source (output valid, output op, output data_in, output item_index, input ready);
  modport sink   (input valid, input op, input data_in, input item_index, output ready);
endinterface

interface dq_out_if;
  logic                       valid;
  logic                       ready;
  logic [dq_pkg::DATA_W-1:0]  data_out;
  logic [1:0]                 status;
  logic [dq_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output data_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input entry_count,
                  output ready);
endinterface

@@ rtl/dq_store.sv @@
// Entry store: one write port and one read port, read data registered.
// Depends on dq_pkg for the access struct and sizes.
module dq_store (
  input  logic                      clk,
  input  dq_pkg::dq_mem_req_t       mem_req,
  output logic [dq_pkg::DATA_W-1:0] mem_rdata
);
  import dq_pkg::*;

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      store_r[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Read port; the data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= store_r[mem_req.raddr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

@@ rtl/dq_ctrl.sv @@
// Request sequencer: front pointer, count, store accesses and the gap-closing walk.
// Depends on dq_pkg and the dq_in_if interface.
module dq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  dq_in_if.sink                     in_ch,
  output dq_pkg::dq_mem_req_t       mem_req,
  input  logic [dq_pkg::DATA_W-1:0] mem_rdata,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output dq_pkg::dq_rsp_t           rsp
);
  import dq_pkg::*;

  dq_state_t          state_r, state_nxt, acc_state;
  logic [ADDR_W-1:0]  front_r, front_nxt, front_dec;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] shift_r, shift_nxt;
  logic [DATA_W-1:0]  res_data_r, res_data_nxt;
  dq_status_t         res_status_r, res_status_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;
  logic               res_mem_r, res_mem_nxt;

  dq_op_t             op;
  logic [COUNT_W-1:0] idx_ext;
  logic               is_full, is_empty, idx_ok, more_shift, shift_more, in_fire;

  // Slot of the entry at an offset from the front, wrapping round the store.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [COUNT_W-1:0] off);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W+1)'(base) + (COUNT_W+1)'(off);
    if (sum >= (COUNT_W+1)'(DEPTH)) begin
      sum = sum - (COUNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Request decode.
  assign op         = dq_op_t'(in_ch.op);
  assign idx_ext    = COUNT_W'(in_ch.item_index);
  assign is_full    = (count_r == COUNT_W'(DEPTH));
  assign is_empty   = (count_r == '0);
  assign idx_ok     = (idx_ext < count_r);
  assign more_shift = ((COUNT_W+1)'(idx_ext) + 1'b1) < (COUNT_W+1)'(count_r);
  assign front_dec  = (front_r == '0) ? ADDR_W'(DEPTH - 1) : front_r - 1'b1;
  // The count is already reduced while the gap is closed.
  assign shift_more = (shift_r + 1'b1) < count_r;

  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_RESP) && rsp_ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign acc_state   = ((op == OP_REMOVE_INDEX) && idx_ok && more_shift) ? S_GRAB : S_RESP;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = acc_state;
        end
      end
      S_GRAB: begin
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (!shift_more) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = in_fire ? acc_state : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Store accesses, pointer and count updates and the pending result.
  always_comb begin
    mem_req        = '0;
    front_nxt      = front_r;
    count_nxt      = count_r;
    shift_nxt      = shift_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_mem_nxt    = res_mem_r;

    rsp_valid        = (state_r == S_RESP);
    rsp.data_out     = res_mem_r ? mem_rdata : res_data_r;
    rsp.status       = res_status_r;
    rsp.entry_count  = res_count_r;

    case (state_r)
      S_GRAB: begin
        // Keep the removed item, then fetch the one behind it.
        res_data_nxt  = mem_rdata;
        res_mem_nxt   = 1'b0;
        mem_req.re    = 1'b1;
        mem_req.raddr = wrap_add(front_r, shift_r + 1'b1);
      end
      S_SHIFT: begin
        // Move one entry a place toward the front, fetch the next.
        mem_req.we    = 1'b1;
        mem_req.waddr = wrap_add(front_r, shift_r);
        mem_req.wdata = mem_rdata;
        if (shift_more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = wrap_add(front_r, shift_r + COUNT_W'(2));
          shift_nxt     = shift_r + 1'b1;
        end
      end
      default: ;
    endcase

    if (in_fire) begin
      res_data_nxt   = '0;
      res_mem_nxt    = 1'b0;
      res_status_nxt = ST_OK;
      shift_nxt      = idx_ext;
      case (op)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = front_dec;
            mem_req.wdata = in_ch.data_in;
            front_nxt     = front_dec;
            count_nxt     = count_r + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wrap_add(front_r, count_r);
            mem_req.wdata = in_ch.data_in;
            count_nxt     = count_r + 1'b1;
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (is_empty) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = front_r;
            res_mem_nxt   = 1'b1;
            if (op == OP_POP_FRONT) begin
              front_nxt = wrap_add(front_r, COUNT_W'(1));
              count_nxt = count_r - 1'b1;
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (is_empty) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = wrap_add(front_r, count_r - 1'b1);
            res_mem_nxt   = 1'b1;
            if (op == OP_POP_BACK) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        OP_READ_INDEX, OP_REMOVE_INDEX: begin
          if (!idx_ok) begin
            res_status_nxt = ST_RANGE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = wrap_add(front_r, idx_ext);
            if (op == OP_REMOVE_INDEX) begin
              count_nxt   = count_r - 1'b1;
              res_mem_nxt = !more_shift;
            end else begin
              res_mem_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res_count_nxt = count_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Walk position and pending result.
  always_ff @(posedge clk) begin
    shift_r      <= shift_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_mem_r    <= res_mem_nxt;
  end

endmodule

@@ rtl/double_ended_queue.sv @@
// Channel     | Direction | Handshake           | Payload
// in_ch       | input     | valid/ready         | op, data_in, item_index
// out_ch      | output    | valid/ready         | data_out, status, entry_count
//
// Push, pop, peek and read give a pending result in the cycle after acceptance, and a
// new item is taken in the cycle the previous result moves into the output register.
// Removing position p of n entries with entries behind it walks the grab and shift
// states. The store has one read and one write port, so the gap closes one entry per
// cycle. Removing the back entry leaves no gap and completes as a read does.
// Reset is synchronous and clears pointer, count and control; the store is not cleared.
// A stalled output holds its result, and the sequencer keeps its own until space frees.
//
// Top level of the double-ended queue. Depends on dq_pkg, dq_if, dq_store, dq_ctrl
// and the assertion macros in double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic clk,
  input  logic rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  dq_mem_req_t       mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              rsp_valid, rsp_ready;
  dq_rsp_t           rsp;
  logic              out_valid_r, out_valid_nxt;
  dq_rsp_t           out_payload_r;

  dq_store u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign rsp_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_payload_r <= rsp;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_out    = out_payload_r.data_out;
  assign out_ch.status      = out_payload_r.status;
  assign out_ch.entry_count = out_payload_r.entry_count;

  // Checks on results and on the hand-over from the sequencer.
  `DQ_ASSERT_IMPLY(a_count_bound, out_valid_r, out_payload_r.entry_count <= COUNT_W'(DEPTH), "entry count above depth")
  `DQ_ASSERT_IMPLY(a_empty_count, out_valid_r && (out_payload_r.status == ST_EMPTY), out_payload_r.entry_count == '0, "empty status with entries held")
  `DQ_ASSERT_IMPLY(a_full_count, out_valid_r && (out_payload_r.status == ST_FULL), out_payload_r.entry_count == COUNT_W'(DEPTH), "full status below depth")
  `DQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "pending result changed while stalled")

endmodule
